/* hw/rtl/clj_pkg.sv */
package clj_pkg;

  // Byte codes that the scanner recognizes.
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  // Source of the word loaded into the output register.
  typedef enum logic [1:0] {
    SRC_IN,
    SRC_HELD,
    SRC_PEND,
    SRC_END
  } clj_src_t;

  // Classes of the input byte.
  typedef struct packed {
    logic is_zero;
    logic is_nl;
    logic is_blank;
    logic is_sptab;
    logic is_hash;
    logic is_bslash;
  } clj_cls_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     load;
    clj_src_t src;
    logic     push;
    logic     flush_step;
    logic     join_run;
    logic     scan_step;
    logic     save_pend;
  } clj_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    clj_cls_t cls;
    logic     slot_free;
    logic     held_empty;
    logic     held_full;
    logic     has_bs;
    logic     bs_deep;
    logic     last_held;
    logic     rd_bs;
    logic     idx_zero;
  } clj_sts_t;

endpackage

/* hw/rtl/config_line_joiner_unit.sv */
// Joins a configuration text, one byte per word, into logical lines: blank lines, leading
// whitespace and '#' comment lines are dropped, and a line ending in a backslash continues
// on the next one. Each logical line leaves as its bytes followed by one word with
// line_end set and out_byte zero; a zero input byte ends the text. A byte is taken when the
// sequencer is idle and the output register is free. Trailing whitespace and backslashes
// wait in a HOLD_DEPTH-entry buffer memory. A byte that releases a held run keeps the input
// closed while the run drains from the memory's single read port, one word per cycle while
// the output register is free, and then while the released byte or the end marker is sent.
// A newline that joins lines with earlier held words also closes the input while the buffer
// is searched backward for a further backslash. There is no clearing pass after reset.
module config_line_joiner_unit
  import clj_pkg::*;
#(
  parameter int HOLD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       line_end
);

  clj_cmd_t cmd;
  clj_sts_t sts;

  // Sequencer.
  clj_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Held run buffer and output register.
  clj_datapath #(
    .HOLD_DEPTH (HOLD_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .line_end  (line_end)
  );

`ifndef SYNTH
  // An end marker carries a zero byte.
  a_end_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && line_end) |-> (out_byte == CH_NUL))
    else $error("end marker with nonzero byte");

  // No word is taken while a result is stalled in the output register.
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // A word taken while the buffer drains would be lost.
  a_one_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.flush_step || cmd.scan_step) |-> !in_ready)
    else $error("input taken during flush or scan");

  // Nothing is offered right after reset.
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
`endif

endmodule

/* hw/rtl/clj_ctrl.sv */
module clj_ctrl
  import clj_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  clj_sts_t sts,
  output clj_cmd_t cmd
);

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_FLUSH = 4'b0010,
    ST_TAIL  = 4'b0100,
    ST_SCAN  = 4'b1000
  } ctrl_state_t;

  // Scanner modes over the text.
  typedef enum logic [4:0] {
    M_START    = 5'b00001,
    M_COMMENT  = 5'b00010,
    M_LINE     = 5'b00100,
    M_JOIN     = 5'b01000,
    M_JCOMMENT = 5'b10000
  } scan_mode_t;

  ctrl_state_t state, state_next;
  scan_mode_t  mode, mode_next;
  logic        tail_end, tail_end_next;
  logic        do_line;

  // A word is taken only when idle and the output register can take a result.
  assign in_ready = (state == ST_IDLE) && sts.slot_free;

  always_comb begin
    cmd           = '0;
    cmd.src       = SRC_IN;
    state_next    = state;
    mode_next     = mode;
    tail_end_next = tail_end;
    do_line       = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          // Decide by mode whether the byte belongs to a line.
          unique case (mode)
            M_START: begin
              if (sts.cls.is_hash) begin
                mode_next = M_COMMENT;
              end else if (!(sts.cls.is_zero || sts.cls.is_nl || sts.cls.is_blank)) begin
                do_line = 1'b1;
              end
            end
            M_COMMENT: begin
              if (sts.cls.is_zero || sts.cls.is_nl) begin
                mode_next = M_START;
              end
            end
            M_LINE: begin
              do_line = 1'b1;
            end
            M_JOIN: begin
              if (sts.cls.is_hash) begin
                mode_next = M_JCOMMENT;
              end else if (!sts.cls.is_sptab) begin
                do_line = 1'b1;
              end
            end
            M_JCOMMENT: begin
              if (sts.cls.is_nl) begin
                mode_next = M_JOIN;
              end else if (sts.cls.is_zero) begin
                do_line = 1'b1;
              end
            end
            default: begin
              mode_next = M_START;
            end
          endcase

          // Line byte handling.
          if (do_line) begin
            if (sts.cls.is_zero || (sts.cls.is_nl && !sts.has_bs)) begin
              mode_next = M_START;
              if (sts.held_empty) begin
                cmd.load = 1'b1;
                cmd.src  = SRC_END;
              end else begin
                tail_end_next = 1'b1;
                state_next    = ST_FLUSH;
              end
            end else if (sts.cls.is_nl) begin
              cmd.join_run = 1'b1;
              mode_next    = M_JOIN;
              if (sts.bs_deep) begin
                state_next = ST_SCAN;
              end
            end else if (sts.cls.is_blank || sts.cls.is_bslash) begin
              cmd.push  = 1'b1;
              mode_next = M_LINE;
              if (sts.held_full) begin
                cmd.load = 1'b1;
                cmd.src  = SRC_HELD;
              end
            end else begin
              mode_next = M_LINE;
              if (sts.held_empty) begin
                cmd.load = 1'b1;
                cmd.src  = SRC_IN;
              end else begin
                cmd.save_pend = 1'b1;
                tail_end_next = 1'b0;
                state_next    = ST_FLUSH;
              end
            end
          end
        end
      end
      ST_FLUSH: begin
        // Send the held run, oldest word first.
        if (sts.slot_free) begin
          cmd.load       = 1'b1;
          cmd.src        = SRC_HELD;
          cmd.flush_step = 1'b1;
          if (sts.last_held) begin
            state_next = ST_TAIL;
          end
        end
      end
      ST_TAIL: begin
        // Send the byte that released the run, or the end marker.
        if (sts.slot_free) begin
          cmd.load   = 1'b1;
          cmd.src    = tail_end ? SRC_END : SRC_PEND;
          state_next = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // Look backward through the held run for an earlier backslash.
        cmd.scan_step = 1'b1;
        if (sts.rd_bs || sts.idx_zero) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      mode     <= M_START;
      tail_end <= 1'b0;
    end else begin
      state    <= state_next;
      mode     <= mode_next;
      tail_end <= tail_end_next;
    end
  end

endmodule

/* hw/rtl/clj_datapath.sv */
module clj_datapath
  import clj_pkg::*;
#(
  parameter int HOLD_DEPTH = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  clj_cmd_t   cmd,
  output clj_sts_t   sts,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       line_end
);

  localparam int AW = $clog2(HOLD_DEPTH);
  localparam int CW = $clog2(HOLD_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(HOLD_DEPTH);
  localparam logic [AW:0]   SUM_DEPTH = (AW + 1)'(HOLD_DEPTH);

  logic [7:0]    held_mem [HOLD_DEPTH];
  logic [7:0]    rd_data;
  logic [7:0]    pend;
  logic [AW-1:0] head, head_next;
  logic [AW-1:0] idx, idx_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] last_bs, last_bs_next;
  logic [AW-1:0] wr_addr, rd_addr;
  logic          wr_en;
  clj_cls_t      cls;

  // Circular address: a + b folded back into the buffer.
  function automatic logic [AW-1:0] addr_wrap(input logic [AW-1:0] a,
                                               input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SUM_DEPTH) begin
      s = s - SUM_DEPTH;
    end
    return s[AW-1:0];
  endfunction

  // Classify the input byte.
  always_comb begin
    cls.is_zero   = (in_byte == CH_NUL);
    cls.is_nl     = (in_byte == CH_NL);
    cls.is_sptab  = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
    cls.is_blank  = cls.is_sptab || (in_byte == CH_VT) || (in_byte == CH_FF) ||
                    (in_byte == CH_CR);
    cls.is_hash   = (in_byte == CH_HASH);
    cls.is_bslash = (in_byte == CH_BSLASH);
  end

  // Status toward the controller.
  always_comb begin
    sts.cls        = cls;
    sts.slot_free  = !out_valid || out_ready;
    sts.held_empty = (count == '0);
    sts.held_full  = (count == DEPTH_C);
    sts.has_bs     = (last_bs != '0);
    sts.bs_deep    = (last_bs > CW'(1));
    sts.last_held  = ((CW'(idx) + CW'(1)) == count);
    sts.rd_bs      = (rd_data == CH_BSLASH);
    sts.idx_zero   = (idx == '0);
  end

  // Held run bookkeeping: head, fill count, read index and last backslash.
  always_comb begin
    head_next    = head;
    count_next   = count;
    idx_next     = idx;
    last_bs_next = last_bs;
    wr_en        = 1'b0;
    wr_addr      = addr_wrap(head, count[AW-1:0]);
    if (cmd.push) begin
      wr_en = 1'b1;
      if (sts.held_full) begin
        // The oldest word leaves; the new one takes its slot.
        wr_addr   = head;
        head_next = (head == AW'(HOLD_DEPTH - 1)) ? '0 : head + AW'(1);
        if (cls.is_bslash) begin
          last_bs_next = DEPTH_C;
        end else if (last_bs != '0) begin
          last_bs_next = last_bs - CW'(1);
        end
      end else begin
        count_next = count + CW'(1);
        if (cls.is_bslash) begin
          last_bs_next = count + CW'(1);
        end
      end
    end
    if (cmd.flush_step) begin
      if (sts.last_held) begin
        idx_next     = '0;
        count_next   = '0;
        last_bs_next = '0;
      end else begin
        idx_next = idx + AW'(1);
      end
    end
    if (cmd.join_run) begin
      // Cut from the last backslash on, then rescan what is left.
      count_next   = last_bs - CW'(1);
      last_bs_next = '0;
      idx_next     = sts.bs_deep ? AW'(last_bs - CW'(2)) : '0;
    end
    if (cmd.scan_step) begin
      if (sts.rd_bs) begin
        last_bs_next = CW'(idx) + CW'(1);
        idx_next     = '0;
      end else if (!sts.idx_zero) begin
        idx_next = idx - AW'(1);
      end
    end
  end

  // Read one word ahead so that the data matches the index register.
  assign rd_addr = addr_wrap(head_next, idx_next);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      held_mem[wr_addr] <= in_byte;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data <= in_byte;
    end else begin
      rd_data <= held_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head    <= '0;
      idx     <= '0;
      count   <= '0;
      last_bs <= '0;
    end else begin
      head    <= head_next;
      idx     <= idx_next;
      count   <= count_next;
      last_bs <= last_bs_next;
    end
  end

  // Pending line byte that waits for the held run to drain.
  always_ff @(posedge clk) begin
    if (cmd.save_pend) begin
      pend <= in_byte;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      case (cmd.src)
        SRC_IN: begin
          out_byte <= in_byte;
          line_end <= 1'b0;
        end
        SRC_HELD: begin
          out_byte <= rd_data;
          line_end <= 1'b0;
        end
        SRC_PEND: begin
          out_byte <= pend;
          line_end <= 1'b0;
        end
        default: begin
          out_byte <= CH_NUL;
          line_end <= 1'b1;
        end
      endcase
    end
  end

endmodule
